// File: design/bofb_pkg.sv
package bofb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = PTR_W + 1;

    // request codes
    localparam logic [1:0] REQ_READY = 2'd0;
    localparam logic [1:0] REQ_PUSH1 = 2'd1;
    localparam logic [1:0] REQ_PUSH2 = 2'd2;
    localparam logic [1:0] REQ_BAD   = 2'd3;

    // destination codes
    localparam logic [1:0] DEST_REQUESTER = 2'd0;
    localparam logic [1:0] DEST_CONSUMER  = 2'd1;
    localparam logic [1:0] DEST_ACK       = 2'd2;
    localparam logic [1:0] DEST_ERROR     = 2'd3;

    // controller to ring memory
    typedef struct packed {
        logic             we;
        logic             re;
        logic [PTR_W-1:0] addr;
        logic [7:0]       wdata;
    } ram_req_t;

endpackage

// File: design/bofb_ring_ram.sv
module bofb_ring_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/bofb_ctrl.sv
module bofb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [7:0]        first_byte,
    input  logic [7:0]        second_byte,
    output logic              busy,
    output bofb_pkg::ram_req_t ram_req,
    input  logic [7:0]        ram_rdata,
    output logic              strobe,
    output logic [1:0]        destination,
    output logic [7:0]        data_byte,
    output logic              overflow,
    output logic              last
);

    import bofb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WRITE2,
        ST_ACK
    } state_t;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             waiting_reg, waiting_next;
    logic [7:0]       second_reg, second_next;
    logic             pend_ovf_reg, pend_ovf_next;
    logic             strobe_reg, strobe_next;
    logic [1:0]       dest_reg, dest_next;
    logic [7:0]       data_reg, data_next;
    logic             ovf_reg, ovf_next;
    logic             last_reg, last_next;

    logic             full;
    logic [CNT_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_ptr_inc;

    assign full   = (count_reg == CNT_W'(RING_DEPTH));
    assign wr_sum = CNT_W'(rd_ptr_reg) + count_reg;
    assign wr_addr = (wr_sum >= CNT_W'(RING_DEPTH)) ? PTR_W'(wr_sum - CNT_W'(RING_DEPTH))
                                                    : PTR_W'(wr_sum);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        count_next    = count_reg;
        waiting_next  = waiting_reg;
        second_next   = second_reg;
        pend_ovf_next = pend_ovf_reg;
        strobe_next   = 1'b0;
        dest_next     = dest_reg;
        data_next     = data_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        ram_req       = '0;
        ram_req.addr  = wr_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        REQ_READY:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_req.re   = 1'b1;
                                ram_req.addr = rd_ptr_reg;
                                rd_ptr_next  = rd_ptr_inc;
                                count_next   = count_reg - CNT_W'(1);
                                state_next   = ST_POP;
                            end
                            else
                            begin
                                waiting_next = 1'b1;
                            end
                        end
                        REQ_PUSH1:
                        begin
                            strobe_next = 1'b1;
                            if (waiting_reg)
                            begin
                                waiting_next  = 1'b0;
                                dest_next     = DEST_CONSUMER;
                                data_next     = first_byte;
                                ovf_next      = 1'b0;
                                last_next     = 1'b0;
                                pend_ovf_next = 1'b0;
                                state_next    = ST_ACK;
                            end
                            else
                            begin
                                dest_next = DEST_ACK;
                                data_next = '0;
                                ovf_next  = full;
                                last_next = 1'b1;
                                if (!full)
                                begin
                                    ram_req.we    = 1'b1;
                                    ram_req.wdata = first_byte;
                                    count_next    = count_reg + CNT_W'(1);
                                end
                            end
                        end
                        REQ_PUSH2:
                        begin
                            pend_ovf_next = full;
                            if (!full)
                            begin
                                ram_req.we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            if (waiting_reg)
                            begin
                                // first byte goes straight out, second is queued
                                waiting_next  = 1'b0;
                                ram_req.wdata = second_byte;
                                strobe_next   = 1'b1;
                                dest_next     = DEST_CONSUMER;
                                data_next     = first_byte;
                                ovf_next      = 1'b0;
                                last_next     = 1'b0;
                                state_next    = ST_ACK;
                            end
                            else
                            begin
                                ram_req.wdata = first_byte;
                                second_next   = second_byte;
                                state_next    = ST_WRITE2;
                            end
                        end
                        REQ_BAD:
                        begin
                            strobe_next = 1'b1;
                            dest_next   = DEST_ERROR;
                            data_next   = '0;
                            ovf_next    = 1'b0;
                            last_next   = 1'b1;
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                strobe_next = 1'b1;
                dest_next   = DEST_REQUESTER;
                data_next   = ram_rdata;
                ovf_next    = 1'b0;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WRITE2:
            begin
                if (!full)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = second_reg;
                    count_next    = count_reg + CNT_W'(1);
                end
                strobe_next = 1'b1;
                dest_next   = DEST_ACK;
                data_next   = '0;
                ovf_next    = pend_ovf_reg | full;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_ACK:
            begin
                strobe_next = 1'b1;
                dest_next   = DEST_ACK;
                data_next   = '0;
                ovf_next    = pend_ovf_reg;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            waiting_reg  <= 1'b0;
            second_reg   <= '0;
            pend_ovf_reg <= 1'b0;
            strobe_reg   <= 1'b0;
            dest_reg     <= '0;
            data_reg     <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            waiting_reg  <= waiting_next;
            second_reg   <= second_next;
            pend_ovf_reg <= pend_ovf_next;
            strobe_reg   <= strobe_next;
            dest_reg     <= dest_next;
            data_reg     <= data_next;
            ovf_reg      <= ovf_next;
            last_reg     <= last_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign strobe      = strobe_reg;
    assign destination = dest_reg;
    assign data_byte   = data_reg;
    assign overflow    = ovf_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count above ring depth");

    a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> (count_reg == '0))
        else $error("consumer waiting while ring holds data");

    a_write2_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE2) |=> (strobe && destination == DEST_ACK && last))
        else $error("pair push did not end in an acknowledge");

    a_bad_req: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_BAD) |=>
        (strobe && destination == DEST_ERROR && last && !overflow))
        else $error("invalid request gave no error word");

    a_fwd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && destination == DEST_CONSUMER) |=> (strobe && destination == DEST_ACK))
        else $error("forwarded byte not followed by acknowledge");
`endif

endmodule

// File: design/byte_output_fifo_with_bypass_top.sv
// Byte output queue: 256-byte ring in one single-port RAM plus a consumer-waiting bypass.
// Result words are registered; a pop first passes ST_POP (RAM read), a pair push ST_WRITE2.
// A request is taken only while idle (busy low), so a pop, a pair push (two writes through
//   the one RAM port) or a bypassed push (forward, then ack) holds off the next request.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Reset (rst_n low, async): ring empty, read pointer 0, no consumer waiting; RAM not cleared.
module byte_output_fifo_with_bypass_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    output logic       strobe,
    output logic [1:0] destination,
    output logic [7:0] data_byte,
    output logic       overflow,
    output logic       last
);

    import bofb_pkg::*;

    ram_req_t   ram_req;
    logic [7:0] ram_rdata;

    // Sequencer: owns read pointer, fill count, waiting flag and the result register.
    // Reads only happen on a pop accepted in idle, and no write lands in that cycle,
    // so a byte written by an earlier request is already visible: no forwarding needed.
    bofb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .busy        (busy),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .strobe      (strobe),
        .destination (destination),
        .data_byte   (data_byte),
        .overflow    (overflow),
        .last        (last)
    );

    // Ring storage: one port, registered read data.
    bofb_ring_ram #(
        .DEPTH  (RING_DEPTH),
        .WIDTH  (8),
        .ADDR_W (PTR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule
